// ===== hdl/stack_machine_execute_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Stack machine execute unit assertion macros
// Clocked assertion helpers used by the execute unit.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTE_UNIT_MACROS_SVH
`define STACK_MACHINE_EXECUTE_UNIT_MACROS_SVH

// property checked at every clock edge outside reset
`define SMEU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked at every clock edge outside reset
`define SMEU_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/stkm_pkg.sv =====
// ----------------------------------------------------------------------------
// Stack machine package
// Word types, instruction codes and fault codes of the execute unit.
// ----------------------------------------------------------------------------
package stkm_pkg;

  localparam int DATA_W = 32;
  localparam int LINE_W = 16;

  localparam logic [4:0] OP_PUSH    = 5'd0;
  localparam logic [4:0] OP_RVALUE  = 5'd1;
  localparam logic [4:0] OP_LVALUE  = 5'd2;
  localparam logic [4:0] OP_POP     = 5'd3;
  localparam logic [4:0] OP_ASSIGN  = 5'd4;
  localparam logic [4:0] OP_COPY    = 5'd5;
  localparam logic [4:0] OP_LABEL   = 5'd6;
  localparam logic [4:0] OP_GOTO    = 5'd7;
  localparam logic [4:0] OP_GOFALSE = 5'd8;
  localparam logic [4:0] OP_GOTRUE  = 5'd9;
  localparam logic [4:0] OP_HALT    = 5'd10;
  localparam logic [4:0] OP_ADD     = 5'd11;
  localparam logic [4:0] OP_SUB     = 5'd12;
  localparam logic [4:0] OP_MUL     = 5'd13;
  localparam logic [4:0] OP_DIV     = 5'd14;
  localparam logic [4:0] OP_MOD     = 5'd15;
  localparam logic [4:0] OP_AND     = 5'd16;
  localparam logic [4:0] OP_NOT     = 5'd17;
  localparam logic [4:0] OP_OR      = 5'd18;
  localparam logic [4:0] OP_NE      = 5'd19;
  localparam logic [4:0] OP_LE      = 5'd20;
  localparam logic [4:0] OP_GE      = 5'd21;
  localparam logic [4:0] OP_LT      = 5'd22;
  localparam logic [4:0] OP_GT      = 5'd23;
  localparam logic [4:0] OP_EQ      = 5'd24;
  localparam logic [4:0] OP_PRINT   = 5'd25;
  localparam logic [4:0] OP_SHOW    = 5'd26;
  localparam logic [4:0] OP_BEGIN   = 5'd27;
  localparam logic [4:0] OP_END     = 5'd28;
  localparam logic [4:0] OP_RETURN  = 5'd29;
  localparam logic [4:0] OP_CALL    = 5'd30;

  localparam logic [1:0] FAULT_NONE   = 2'd0;
  localparam logic [1:0] FAULT_DFULL  = 2'd1;
  localparam logic [1:0] FAULT_RETURN = 2'd2;
  localparam logic [1:0] FAULT_FRAME  = 2'd3;

  localparam logic [1:0] SCOPE_TOP    = 2'd0;
  localparam logic [1:0] SCOPE_READ   = 2'd1;
  localparam logic [1:0] SCOPE_WRITE  = 2'd2;

  typedef struct packed {
    logic [4:0]        op;
    logic [DATA_W-1:0] imm_value;
    logic [5:0]        var_index;
    logic [LINE_W-1:0] target_line;
    logic [LINE_W-1:0] instr_line;
  } stkm_cmd_t;

  typedef struct packed {
    logic              print_valid;
    logic [DATA_W-1:0] print_value;
    logic              redirect;
    logic [LINE_W-1:0] redirect_line;
    logic              halted;
    logic [1:0]        fault;
  } stkm_rsp_t;

endpackage

// ===== hdl/stkm_div.sv =====
// ----------------------------------------------------------------------------
// Stack machine divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stkm_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [stkm_pkg::DATA_W-1:0] dividend,
  input  logic [stkm_pkg::DATA_W-1:0] divisor,
  output logic                      done,
  output logic [stkm_pkg::DATA_W-1:0] quotient,
  output logic [stkm_pkg::DATA_W-1:0] remainder
);
  import stkm_pkg::*;

  localparam int CNT_W = $clog2(DATA_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W-1:0] dsr;
  logic [DATA_W:0]   shifted;
  logic              fits;

  assign shifted = {remainder, quotient[DATA_W-1]};
  assign fits    = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        cnt       <= CNT_W'(DATA_W);
        dsr       <= divisor;
        quotient  <= dividend;
        remainder <= '0;
      end else if (busy) begin
        remainder <= fits ? DATA_W'(shifted - {1'b0, dsr}) : DATA_W'(shifted);
        quotient  <= {quotient[DATA_W-2:0], fits};
        cnt       <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/stack_machine_execute_unit.sv =====
// Flow: S_IDLE, S_RD_TOP, S_RD_SEC, S_EXEC; DIV and MOD add S_DIV and S_WB.
// A new instruction is accepted only in S_IDLE with no result word pending;
// the single data stack port reads top and second in turn, the divider
// takes 32 steps. Reset: synchronous; clears pointers, scope and halt, sets
// frame depth to one, then S_CLR clears the valid bits before cmd_ready
// rises. Stack, variable and return memories are not cleared.
// ----------------------------------------------------------------------------
// Stack machine execute unit
// Executes one resolved stack-machine instruction per command word.
// ----------------------------------------------------------------------------
`include "stack_machine_execute_unit_macros.svh"

module stack_machine_execute_unit #(
  parameter int STACK_DEPTH    = 1024,
  parameter int FRAME_COUNT    = 16,
  parameter int VARS_PER_FRAME = 64,
  parameter int RETURN_DEPTH   = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  stkm_pkg::stkm_cmd_t cmd,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output stkm_pkg::stkm_rsp_t rsp
);
  import stkm_pkg::*;

  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int SA_W = $clog2(STACK_DEPTH);
  localparam int FD_W = $clog2(FRAME_COUNT + 1);
  localparam int FI_W = $clog2(FRAME_COUNT);
  localparam int VS_W = $clog2(VARS_PER_FRAME);
  localparam int VA_W = $clog2(FRAME_COUNT * VARS_PER_FRAME);
  localparam int RP_W = $clog2(RETURN_DEPTH + 1);
  localparam int RA_W = $clog2(RETURN_DEPTH);
  localparam logic [DATA_W-1:0] ONES = '1;

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD_TOP, S_RD_SEC, S_EXEC, S_DIV, S_WB} state_t;

  state_t            state;
  stkm_cmd_t         c;
  logic [SP_W-1:0]   sp;
  logic [FD_W-1:0]   fd;
  logic [1:0]        scope;
  logic [RP_W-1:0]   rp;
  logic              halt_flag;
  logic [DATA_W-1:0] a_reg;
  logic [FI_W-1:0]   clr_idx;

  logic [DATA_W-1:0] dmem [STACK_DEPTH];
  logic [DATA_W-1:0] vmem [FRAME_COUNT*VARS_PER_FRAME];
  logic [LINE_W-1:0] rmem [RETURN_DEPTH];
  logic [VARS_PER_FRAME-1:0] vvalid [FRAME_COUNT];

  logic [DATA_W-1:0] d_rdata, v_rdata;
  logic [LINE_W-1:0] r_rdata;
  logic [VARS_PER_FRAME-1:0] vv_rdata;
  logic [SA_W-1:0]   d_raddr;

  logic [FI_W-1:0]   top_fr, caller_fr, rd_fr, wr_fr;
  logic              has_caller, rd_ok, wr_ok;
  logic [VA_W-1:0]   rd_vaddr, wr_vaddr;
  logic [VS_W-1:0]   rd_slot, wr_slot;

  logic [DATA_W-1:0] a_val, b_val, alu, rv_val;
  logic [1:0]        pops;
  logic [SP_W-1:0]   sp_pop;
  logic              push_req, push_ok, is_div, commit;
  logic [DATA_W-1:0] push_val;
  logic [1:0]        fault_c;
  logic              redir_c;
  logic [LINE_W-1:0] rline_c;

  logic              div_done;
  logic [DATA_W-1:0] div_q, div_r;

  assign cmd_ready = (state == S_IDLE) && !rsp_valid;

  // frame selection
  assign top_fr     = FI_W'(fd - FD_W'(1));
  assign caller_fr  = FI_W'(fd - FD_W'(2));
  assign has_caller = fd >= FD_W'(2);
  assign rd_fr      = (scope == SCOPE_READ) ? caller_fr : top_fr;
  assign wr_fr      = (scope == SCOPE_WRITE) ? caller_fr : top_fr;
  assign rd_slot    = VS_W'(c.var_index);
  assign wr_slot    = VS_W'(b_val);
  assign rd_ok      = ((scope != SCOPE_READ) || has_caller)
                      && (32'(c.var_index) < 32'(VARS_PER_FRAME));
  assign wr_ok      = ((scope != SCOPE_WRITE) || has_caller)
                      && (b_val < 32'(VARS_PER_FRAME));
  assign rd_vaddr   = VA_W'(VA_W'(rd_fr) * VA_W'(VARS_PER_FRAME) + VA_W'(rd_slot));
  assign wr_vaddr   = VA_W'(VA_W'(wr_fr) * VA_W'(VARS_PER_FRAME) + VA_W'(wr_slot));

  assign d_raddr = (state == S_RD_TOP) ? SA_W'(sp - SP_W'(1)) : SA_W'(sp - SP_W'(2));

  // memory reads, registered
  always_ff @(posedge clk) begin
    if (state == S_RD_TOP || state == S_RD_SEC) begin
      d_rdata <= dmem[d_raddr];
    end
    if (state == S_RD_TOP) begin
      v_rdata  <= vmem[rd_vaddr];
      r_rdata  <= rmem[RA_W'(rp - RP_W'(1))];
      vv_rdata <= vvalid[(c.op == OP_ASSIGN) ? wr_fr : rd_fr];
    end
  end

  assign a_val  = a_reg;
  assign b_val  = (sp >= SP_W'(2)) ? d_rdata : ONES;
  assign is_div = (c.op == OP_DIV) || (c.op == OP_MOD);
  assign rv_val = (rd_ok && vv_rdata[rd_slot]) ? v_rdata : '0;

  always_comb begin
    unique case (c.op)
      OP_ADD:  alu = b_val + a_val;
      OP_SUB:  alu = b_val - a_val;
      OP_MUL:  alu = DATA_W'(b_val * a_val);
      OP_DIV:  alu = (a_val == '0) ? ONES : div_q;
      OP_MOD:  alu = (a_val == '0) ? b_val : div_r;
      OP_AND:  alu = b_val & a_val;
      OP_OR:   alu = b_val | a_val;
      OP_NE:   alu = DATA_W'(b_val != a_val);
      OP_LE:   alu = DATA_W'(b_val <= a_val);
      OP_GE:   alu = DATA_W'(b_val >= a_val);
      OP_LT:   alu = DATA_W'(b_val < a_val);
      OP_GT:   alu = DATA_W'(b_val > a_val);
      OP_EQ:   alu = DATA_W'(b_val == a_val);
      default: alu = ~a_val;
    endcase
  end

  always_comb begin
    pops     = 2'd0;
    push_req = 1'b0;
    push_val = alu;
    fault_c  = FAULT_NONE;
    redir_c  = 1'b0;
    rline_c  = '0;
    unique case (c.op)
      OP_PUSH: begin
        push_req = 1'b1;
        push_val = c.imm_value;
      end
      OP_RVALUE: begin
        push_req = 1'b1;
        push_val = rv_val;
        if (!rd_ok) fault_c = FAULT_FRAME;
      end
      OP_LVALUE: begin
        push_req = 1'b1;
        push_val = DATA_W'(c.var_index);
      end
      OP_POP, OP_PRINT: pops = 2'd1;
      OP_ASSIGN: begin
        pops = 2'd2;
        if (!wr_ok) fault_c = FAULT_FRAME;
      end
      OP_COPY: begin
        push_req = sp != '0;
        push_val = a_val;
      end
      OP_GOTO: begin
        redir_c = 1'b1;
        rline_c = c.target_line;
      end
      OP_GOFALSE, OP_GOTRUE: begin
        pops    = 2'd1;
        redir_c = (a_val == '0) == (c.op == OP_GOFALSE);
        rline_c = redir_c ? c.target_line : '0;
      end
      OP_NOT: begin
        pops     = 2'd1;
        push_req = 1'b1;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR,
      OP_NE, OP_LE, OP_GE, OP_LT, OP_GT, OP_EQ: begin
        pops     = 2'd2;
        push_req = 1'b1;
      end
      OP_BEGIN: if (fd >= FD_W'(FRAME_COUNT)) fault_c = FAULT_FRAME;
      OP_END:   if (fd <= FD_W'(1)) fault_c = FAULT_FRAME;
      OP_RETURN: begin
        if (rp == '0) begin
          fault_c = FAULT_RETURN;
        end else begin
          redir_c = 1'b1;
          rline_c = r_rdata;
        end
      end
      OP_CALL: begin
        if (rp >= RP_W'(RETURN_DEPTH)) begin
          fault_c = FAULT_RETURN;
        end else begin
          redir_c = 1'b1;
          rline_c = c.target_line;
        end
      end
      default: ;
    endcase
    sp_pop  = (SP_W'(pops) >= sp) ? '0 : sp - SP_W'(pops);
    push_ok = push_req && (sp_pop < SP_W'(STACK_DEPTH));
    if (push_req && !push_ok && fault_c == FAULT_NONE
        && (c.op == OP_PUSH || c.op == OP_RVALUE || c.op == OP_LVALUE || c.op == OP_COPY)) begin
      fault_c = FAULT_DFULL;
    end
  end

  assign commit = !halt_flag && (((state == S_EXEC) && !is_div) || (state == S_WB));

  always_ff @(posedge clk) begin
    if (commit && push_ok) dmem[SA_W'(sp_pop)] <= push_val;
    if (commit && c.op == OP_ASSIGN && wr_ok) vmem[wr_vaddr] <= a_val;
    if (commit && c.op == OP_CALL && fault_c == FAULT_NONE) rmem[RA_W'(rp)] <= c.instr_line;
  end

  // valid bits: one frame word per access
  always_ff @(posedge clk) begin
    if (state == S_CLR) begin
      vvalid[clr_idx] <= '0;
    end else if (commit && c.op == OP_ASSIGN && wr_ok) begin
      vvalid[wr_fr] <= vv_rdata | (VARS_PER_FRAME'(1) << wr_slot);
    end else if (commit && c.op == OP_BEGIN && fault_c == FAULT_NONE) begin
      vvalid[FI_W'(fd)] <= '0;
    end
  end

  stkm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     ((state == S_EXEC) && is_div && !halt_flag),
    .dividend  (b_val),
    .divisor   (a_val),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_idx   <= '0;
      sp        <= '0;
      fd        <= FD_W'(1);
      scope     <= SCOPE_TOP;
      rp        <= '0;
      halt_flag <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr_idx <= clr_idx + FI_W'(1);
          if (clr_idx == FI_W'(FRAME_COUNT - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            c     <= cmd;
            state <= S_RD_TOP;
          end
        end
        S_RD_TOP: state <= S_RD_SEC;
        S_RD_SEC: begin
          a_reg <= (sp != '0) ? d_rdata : ONES;
          state <= S_EXEC;
        end
        S_EXEC, S_WB: begin
          if (halt_flag) begin
            rsp       <= '{print_valid: 1'b0, print_value: '0, redirect: 1'b0,
                           redirect_line: '0, halted: 1'b1, fault: FAULT_NONE};
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end else if (state == S_EXEC && is_div) begin
            state <= S_DIV;
          end else begin
            sp    <= push_ok ? sp_pop + SP_W'(1) : sp_pop;
            unique case (c.op)
              OP_HALT:  halt_flag <= 1'b1;
              OP_BEGIN: if (fault_c == FAULT_NONE) begin
                fd    <= fd + FD_W'(1);
                scope <= SCOPE_READ;
              end
              OP_END: if (fault_c == FAULT_NONE) begin
                fd    <= fd - FD_W'(1);
                scope <= SCOPE_TOP;
              end
              OP_RETURN: if (fault_c == FAULT_NONE) begin
                rp    <= rp - RP_W'(1);
                scope <= SCOPE_WRITE;
              end
              OP_CALL: if (fault_c == FAULT_NONE) begin
                rp    <= rp + RP_W'(1);
                scope <= SCOPE_TOP;
              end
              default: ;
            endcase
            rsp.print_valid   <= c.op == OP_PRINT;
            rsp.print_value   <= (c.op == OP_PRINT) ? a_val : '0;
            rsp.redirect      <= redir_c;
            rsp.redirect_line <= rline_c;
            rsp.halted        <= c.op == OP_HALT;
            rsp.fault         <= fault_c;
            rsp_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end
        S_DIV: if (div_done) state <= S_WB;
        default: state <= S_IDLE;
      endcase
    end
  end

  `SMEU_ASSERT(a_sp_range, sp <= SP_W'(STACK_DEPTH), "data stack pointer beyond depth")
  `SMEU_ASSERT(a_fd_range, (fd >= FD_W'(1)) && (fd <= FD_W'(FRAME_COUNT)), "frame depth out of range")
  `SMEU_ASSERT(a_rp_range, rp <= RP_W'(RETURN_DEPTH), "return pointer beyond depth")
  `SMEU_ASSERT_IMP(a_halt_sticky, halt_flag, halt_flag, "halt flag cleared")
  `SMEU_ASSERT(a_halt_rsp, !(rsp_valid && rsp.halted) || halt_flag, "halted word without halt")

endmodule
